FILE: rtl/rgbds_pkg.sv
// ----------------------------------------------------------------------------
// RGB32 downsampler package
// Shared widths, register indexes, control types and the lane average.
// ----------------------------------------------------------------------------
package rgbds_pkg;

   localparam int PIXEL_W      = 32;
   localparam int DISP_DIM_W   = 11;
   localparam int FRAME_DIM_W  = 12;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 12;

   localparam logic [PIXEL_W-1:0] LANE_MASK = 32'hfefe_fefe;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DISPLAY_WIDTH  = 2'd0,
      CSR_DISPLAY_HEIGHT = 2'd1,
      CSR_FRAME_WIDTH    = 2'd2,
      CSR_FRAME_HEIGHT   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                   pass;
      logic                   down;
      logic                   restart;
      logic [FRAME_DIM_W-1:0] frame_width;
      logic [FRAME_DIM_W-1:0] frame_height;
   } mode_type;

   function automatic logic [PIXEL_W-1:0] lane_avg(input logic [PIXEL_W-1:0] a,
                                                   input logic [PIXEL_W-1:0] b);
      lane_avg = (((a ^ b) & LANE_MASK) >> 1) + (a & b);
   endfunction

endpackage

FILE: rtl/rgbds_if.sv
// ----------------------------------------------------------------------------
// RGB32 downsampler stream interfaces
// Valid/ready channels for source pixels and display pixels.
// ----------------------------------------------------------------------------
interface rgbds_req_if
   import rgbds_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] source_pixel;

   modport source (output valid, output source_pixel, input ready);
   modport sink (input valid, input source_pixel, output ready);
endinterface

interface rgbds_rsp_if
   import rgbds_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] display_pixel;
   logic               row_end;
   logic               frame_end;

   modport source (output valid, output display_pixel, output row_end,
                   output frame_end, input ready);
   modport sink (input valid, input display_pixel, input row_end,
                 input frame_end, output ready);
endinterface

FILE: rtl/rgbds_csr.sv
// ----------------------------------------------------------------------------
// RGB32 downsampler configuration registers
// Holds the display and frame sizes and decodes the operating mode.
// ----------------------------------------------------------------------------
module rgbds_csr
   import rgbds_pkg::*;
#(
   parameter int MAX_DISPLAY_WIDTH  = 1024,
   parameter int MAX_DISPLAY_HEIGHT = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output mode_type               mode
);

   localparam logic [DISP_DIM_W+1:0] MaxW = (DISP_DIM_W+2)'(MAX_DISPLAY_WIDTH);
   localparam logic [DISP_DIM_W+1:0] MaxH = (DISP_DIM_W+2)'(MAX_DISPLAY_HEIGHT);

   logic [DISP_DIM_W-1:0]  disp_w_ff, disp_h_ff;
   logic [FRAME_DIM_W-1:0] frame_w_ff, frame_h_ff;
   logic                   dims_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         disp_w_ff  <= DISP_DIM_W'(640);
         disp_h_ff  <= DISP_DIM_W'(480);
         frame_w_ff <= FRAME_DIM_W'(640);
         frame_h_ff <= FRAME_DIM_W'(480);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DISPLAY_WIDTH:  disp_w_ff  <= csr_wdata[DISP_DIM_W-1:0];
            CSR_DISPLAY_HEIGHT: disp_h_ff  <= csr_wdata[DISP_DIM_W-1:0];
            CSR_FRAME_WIDTH:    frame_w_ff <= csr_wdata[FRAME_DIM_W-1:0];
            CSR_FRAME_HEIGHT:   frame_h_ff <= csr_wdata[FRAME_DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      dims_ok = (disp_w_ff != '0) && (disp_h_ff != '0) &&
                ({2'b00, disp_w_ff} <= MaxW) && ({2'b00, disp_h_ff} <= MaxH);
      mode.pass = dims_ok &&
                  (frame_w_ff == {1'b0, disp_w_ff}) &&
                  (frame_h_ff == {1'b0, disp_h_ff});
      mode.down = dims_ok &&
                  (frame_w_ff == {disp_w_ff, 1'b0}) &&
                  (frame_h_ff == {disp_h_ff, 1'b0});
      mode.restart      = csr_we;
      mode.frame_width  = frame_w_ff;
      mode.frame_height = frame_h_ff;
   end

endmodule

FILE: rtl/rgbds_line_buf.sv
// ----------------------------------------------------------------------------
// RGB32 downsampler line buffer
// Single-port-write, registered-read memory of even-row pair averages.
// ----------------------------------------------------------------------------
module rgbds_line_buf
   import rgbds_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [PIXEL_W-1:0]       wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [PIXEL_W-1:0]       rd_data
);

   logic [PIXEL_W-1:0] mem [DEPTH];
   logic [PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rgb32_two_by_two_downsampler.sv
// ----------------------------------------------------------------------------
// RGB32 two-by-two downsampler
// Passes pixels through, or reduces each 2x2 block to its lane-wise average.
// ----------------------------------------------------------------------------
// Pipeline: a result beat is held in the s1 registers, then in the output registers.
// Throughput: one source pixel per clock unless rsp_bus stalls, set by the single
// line buffer port pair (a write for an even row, a registered read every pixel).
// Reset: synchronous; sizes return to 640x480, position counters clear, and the
// line buffer is not cleared since every entry is written before it is read.
// ----------------------------------------------------------------------------
module rgb32_two_by_two_downsampler
   import rgbds_pkg::*;
#(
   parameter int MAX_DISPLAY_WIDTH  = 1024,
   parameter int MAX_DISPLAY_HEIGHT = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   rgbds_req_if.sink              req_bus,
   rgbds_rsp_if.source            rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(MAX_DISPLAY_WIDTH);
   localparam logic [FRAME_DIM_W:0] LastSlot = (FRAME_DIM_W+1)'(MAX_DISPLAY_WIDTH - 1);

   mode_type mode;

   logic [FRAME_DIM_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [PIXEL_W-1:0]     held_ff, held_in;

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_pass_ff;
   logic [PIXEL_W-1:0]     s1_data_ff;
   logic                   s1_row_end_ff, s1_frame_end_ff;

   logic                   out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0]     out_pixel_ff;
   logic                   out_row_end_ff, out_frame_end_ff;

   logic                   accept, out_free, s1_free;
   logic                   last_col, last_row, hold_left, store_pair, emit;
   logic [PIXEL_W-1:0]     pair, mem_rd_data;
   logic [FRAME_DIM_W:0]   slot_wide, slot_clip;
   logic [AW-1:0]          slot;

   rgbds_csr #(
      .MAX_DISPLAY_WIDTH  (MAX_DISPLAY_WIDTH),
      .MAX_DISPLAY_HEIGHT (MAX_DISPLAY_HEIGHT)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mode      (mode)
   );

   rgbds_line_buf #(
      .DEPTH (MAX_DISPLAY_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (accept && store_pair),
      .wr_addr (slot),
      .wr_data (pair),
      .rd_en   (accept),
      .rd_addr (slot),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      out_free = !out_valid_ff || rsp_bus.ready;
      s1_free  = !s1_valid_ff || out_free;
      req_bus.ready = s1_free;
      accept   = req_bus.valid && s1_free;

      last_col   = col_ff >= (mode.frame_width - FRAME_DIM_W'(1));
      last_row   = row_ff >= (mode.frame_height - FRAME_DIM_W'(1));
      hold_left  = mode.down && !col_ff[0] && !last_col;
      store_pair = mode.down && !hold_left && !row_ff[0] && !last_row;
      emit       = mode.pass || (mode.down && !hold_left && !store_pair);
      pair       = lane_avg(held_ff, req_bus.source_pixel);

      slot_wide = {2'b00, col_ff[FRAME_DIM_W-1:1]};
      slot_clip = (slot_wide >= LastSlot) ? LastSlot : slot_wide;
      slot      = slot_clip[AW-1:0];

      held_in = held_ff;
      if (accept && hold_left) begin
         held_in = req_bus.source_pixel;
      end

      col_in = col_ff;
      row_in = row_ff;
      if (mode.restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept && (mode.pass || mode.down)) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + FRAME_DIM_W'(1);
         end else begin
            col_in = col_ff + FRAME_DIM_W'(1);
         end
      end

      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = emit;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         held_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         held_ff      <= held_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pass_ff      <= mode.pass;
         s1_data_ff      <= mode.pass ? req_bus.source_pixel : pair;
         s1_row_end_ff   <= last_col;
         s1_frame_end_ff <= last_col && last_row;
      end
      if (out_free && s1_valid_ff) begin
         out_pixel_ff     <= s1_pass_ff ? s1_data_ff : lane_avg(mem_rd_data, s1_data_ff);
         out_row_end_ff   <= s1_row_end_ff;
         out_frame_end_ff <= s1_frame_end_ff;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.display_pixel = out_pixel_ff;
   assign rsp_bus.row_end       = out_row_end_ff;
   assign rsp_bus.frame_end     = out_frame_end_ff;

endmodule

FILE: dv/rgb32_two_by_two_downsampler_tb.sv
// ----------------------------------------------------------------------------
// RGB32 two-by-two downsampler testbench
// Streams source pixels through passthrough, 2x2 reduction and unsupported
// size settings, with random gaps on both channels. A scoreboard predicts
// every display beat and checks each one field by field in arrival order.
// ----------------------------------------------------------------------------
module rgb32_two_by_two_downsampler_tb
   import rgbds_pkg::*;
   ;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W         = 1024;
   localparam int MAX_H         = 1024;
   localparam int LINE_SLOTS    = 1024;
   localparam int SETTLE_CYCLES = 8;
   localparam int FINAL_WAIT    = 20000;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_ITEMS  = 1000;
   localparam int IDLE_PERCENT  = 36;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               row_end;
      logic               frame_end;
   } display_beat_type;

   class downsample_scoreboard;
      logic [DISP_DIM_W-1:0]  disp_w;
      logic [DISP_DIM_W-1:0]  disp_h;
      logic [FRAME_DIM_W-1:0] frm_w;
      logic [FRAME_DIM_W-1:0] frm_h;
      logic [DISP_DIM_W-1:0]  col;
      logic [DISP_DIM_W-1:0]  row;
      logic [PIXEL_W-1:0]     left_pixel;
      logic [PIXEL_W-1:0]     pair_row [LINE_SLOTS];
      display_beat_type       expected_q [$];
      int                     errors;

      function new();
         disp_w     = 11'd640;
         disp_h     = 11'd480;
         frm_w      = 12'd640;
         frm_h      = 12'd480;
         col        = '0;
         row        = '0;
         left_pixel = '0;
         errors     = 0;
      endfunction

      function logic [PIXEL_W-1:0] lane_mean(logic [PIXEL_W-1:0] a, logic [PIXEL_W-1:0] b);
         logic [PIXEL_W-1:0] m;
         logic [8:0]         s;
         for (int k = 0; k < 4; k++) begin
            s = a[8*k +: 8] + b[8*k +: 8];
            m[8*k +: 8] = s[8:1];
         end
         return m;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_DISPLAY_WIDTH: begin
               disp_w = value[DISP_DIM_W-1:0];
            end
            CSR_DISPLAY_HEIGHT: begin
               disp_h = value[DISP_DIM_W-1:0];
            end
            CSR_FRAME_WIDTH: begin
               frm_w = value[FRAME_DIM_W-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               frm_h = value[FRAME_DIM_W-1:0];
            end
            default: begin
               return;
            end
         endcase
         col = '0;
         row = '0;
      endfunction

      function void note_source(logic [PIXEL_W-1:0] pix);
         bit                 size_ok;
         bit                 pass;
         bit                 down;
         bit                 last_col;
         bit                 last_row;
         logic [PIXEL_W-1:0] pair;
         int                 slot;
         display_beat_type   beat;
         size_ok = disp_w != 0 && disp_h != 0 && int'(disp_w) <= MAX_W &&
                   int'(disp_h) <= MAX_H;
         pass = size_ok && int'(frm_w) == int'(disp_w) && int'(frm_h) == int'(disp_h);
         down = size_ok && int'(frm_w) == 2 * int'(disp_w) &&
                int'(frm_h) == 2 * int'(disp_h);
         if (pass || down) begin
            last_col = int'(col) >= int'(frm_w) - 1;
            last_row = int'(row) >= int'(frm_h) - 1;
            beat.row_end   = last_col;
            beat.frame_end = last_col && last_row;
            if (pass) begin
               beat.pixel = pix;
               expected_q.push_back(beat);
            end else if (!col[0] && !last_col) begin
               left_pixel = pix;
            end else begin
               pair = lane_mean(left_pixel, pix);
               slot = int'(col) >> 1;
               if (slot >= LINE_SLOTS) slot = LINE_SLOTS - 1;
               if (!row[0] && !last_row) begin
                  pair_row[slot] = pair;
               end else begin
                  beat.pixel = lane_mean(pair_row[slot], pair);
                  expected_q.push_back(beat);
               end
            end
            if (last_col) begin
               col = '0;
               row = last_row ? '0 : row + 1'b1;
            end else begin
               col = col + 1'b1;
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report(string what);
         errors++;
         if (errors <= 100) $display("mismatch: %s", what);
      endtask

      task check_display(logic [PIXEL_W-1:0] pix, logic re, logic fe);
         display_beat_type beat;
         if (expected_q.size() == 0) begin
            report($sformatf("display beat %08h arrived with nothing expected", pix));
         end else begin
            beat = expected_q.pop_front();
            if (pix !== beat.pixel)
               report($sformatf("display_pixel %08h, expected %08h", pix, beat.pixel));
            if (re !== beat.row_end)
               report($sformatf("row_end %b, expected %b (pixel %08h)", re, beat.row_end,
                                beat.pixel));
            if (fe !== beat.frame_end)
               report($sformatf("frame_end %b, expected %b (pixel %08h)", fe,
                                beat.frame_end, beat.pixel));
         end
      endtask

      task report_leftovers();
         display_beat_type beat;
         while (expected_q.size() != 0) begin
            beat = expected_q.pop_front();
            report($sformatf("display beat %08h never arrived", beat.pixel));
         end
      endtask
   endclass

   logic clock  = 1'b0;
   logic reset  = 1'b1;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   bit                     steady    = 1'b0;
   int                     cycle_count = 0;

   downsample_scoreboard sb = new();

   rgbds_req_if req_bus ();
   rgbds_rsp_if rsp_bus ();

   rgb32_two_by_two_downsampler dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            sb.check_display(rsp_bus.display_pixel, rsp_bus.row_end, rsp_bus.frame_end);
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
      if (!steady) begin
         while ($urandom_range(0, 99) < IDLE_PERCENT) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid        <= 1'b1;
      req_bus.source_pixel <= pix;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_source(pix);
   endtask

   task automatic stream_random(input int count);
      repeat (count) send_pixel($urandom());
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      sb.write_register(idx, CSR_DATA_W'(value));
      @(posedge clock);
   endtask

   task automatic configure(input int dw, input int dh, input int fw, input int fh);
      drain();
      write_csr(CSR_DISPLAY_WIDTH, dw);
      write_csr(CSR_DISPLAY_HEIGHT, dh);
      write_csr(CSR_FRAME_WIDTH, fw);
      write_csr(CSR_FRAME_HEIGHT, fh);
      csr_we <= 1'b0;
   endtask

   initial begin
      int kind;
      int dw;
      int dh;
      int fw;
      int fh;
      int count;
      int random_items;
      int waited;
      random_items = 0;
      waited       = 0;
      req_bus.valid        <= 1'b0;
      req_bus.source_pixel <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset sizes give passthrough at 640x480.
      send_pixel(32'h0000_0000);
      send_pixel(32'hffff_ffff);
      send_pixel(32'ha5a5_a5a5);

      configure(2, 2, 2, 2);
      send_pixel(32'hffff_ffff);
      send_pixel(32'h0000_0000);
      send_pixel(32'h8080_8080);
      send_pixel(32'h7f7f_7f7f);

      configure(1, 1, 2, 2);
      send_pixel(32'hffff_ffff);
      send_pixel(32'hfefe_fefe);
      send_pixel(32'h0101_0101);
      send_pixel(32'h0000_0000);
      send_pixel(32'hff00_ff00);
      send_pixel(32'h00ff_00ff);
      send_pixel(32'h1234_5678);
      send_pixel(32'h8765_4321);

      configure(0, 1, 0, 1);
      send_pixel(32'hdead_beef);
      send_pixel(32'h0bad_f00d);

      // Display width keeps only its low bits and ends up above the maximum.
      configure(12'hfff, 1, 12'hfff, 1);
      send_pixel(32'hffff_ffff);
      send_pixel(32'h5555_5555);

      configure(3, 2, 5, 4);
      send_pixel(32'haaaa_aaaa);
      send_pixel(32'h3c3c_3c3c);

      configure(1, 1, 1, 1);
      send_pixel(32'hc001_d00d);

      // The largest supported sizes, checked on the first pixels of a frame.
      configure(MAX_W, 1, MAX_W, 1);
      stream_random(8);
      configure(1, MAX_H, 1, MAX_H);
      stream_random(8);
      configure(MAX_W, 1, 2 * MAX_W, 2);
      stream_random(8);
      configure(1, MAX_H, 2, 2 * MAX_H);
      stream_random(8);

      configure(32, 4, 64, 8);
      steady = 1'b1;
      stream_random(512);
      steady = 1'b0;

      while (random_items < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 65) begin
            dw = $urandom_range(1, 8);
            dh = $urandom_range(1, 4);
            fw = 2 * dw;
            fh = 2 * dh;
         end else if (kind < 85) begin
            dw = $urandom_range(1, 12);
            dh = $urandom_range(1, 6);
            fw = dw;
            fh = dh;
         end else begin
            dw = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 16);
            dh = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if ($urandom_range(0, 3) == 0) dw = $urandom_range(MAX_W + 1, 2047);
            fw = 2 * dw + 1;
            fh = $urandom_range(0, 20);
         end
         configure(dw, dh, fw, fh);
         if (kind < 85) begin
            count = $urandom_range(1, 3) * fw * fh;
            if ($urandom_range(0, 99) < 15) count = $urandom_range(1, fw * fh);
            random_items += count;
         end else begin
            count = 6;
         end
         stream_random(count);
      end

      req_bus.valid <= 1'b0;
      while (sb.pending() != 0 && waited < FINAL_WAIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.report_leftovers();
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/rgbds_pkg.sv
rtl/rgbds_if.sv
rtl/rgbds_csr.sv
rtl/rgbds_line_buf.sv
rtl/rgb32_two_by_two_downsampler.sv
dv/rgb32_two_by_two_downsampler_tb.sv
